[src/assert_macros.svh]
// assertion macros shared by the timer table rtl
// expects signals named clk and rst_n in the including module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent checked in the cycle after the antecedent
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/mstt_pkg.sv]
// types, codes and helpers for the multi-slot timer table
// no dependencies
`timescale 1ns / 1ps

package mstt_pkg;

  localparam int FIRE_CAP = 8;
  localparam int FIRE_W   = $clog2(FIRE_CAP + 1);

  typedef enum logic [1:0] {
    FUNC_SET    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_RSVD   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    STAT_OK        = 3'd0,
    STAT_NOT_FOUND = 3'd1,
    STAT_INVALID   = 3'd2,
    STAT_EXISTS    = 3'd3,
    STAT_FULL      = 3'd4
  } status_t;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_EXPIRY = 1'b1;

  typedef struct packed {
    func_t       func;
    logic [15:0] tmr_id;
    logic [4:0]  owner_state;
    logic [31:0] delay;
    logic [31:0] reload_period;
    logic [31:0] now;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    status_t     status;
    logic [15:0] fired_tmr_id;
    logic [4:0]  fired_state;
    logic [31:0] next_due;
    logic        last;
  } out_item_t;

  // one timer slot as held in the slot memory, id zero means free
  typedef struct packed {
    logic [15:0] id;
    logic [4:0]  owner;
    logic [31:0] due;
    logic [31:0] period;
  } slot_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

[src/mstt_slot_ram.sv]
// slot memory: one write port, one registered read port
// entries never written since reset read as a free slot; uses mstt_pkg
`timescale 1ns / 1ps

module mstt_slot_ram #(
  parameter int SLOTS = 8,
  parameter int AW    = 3
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  mstt_pkg::slot_t wdata,
  input  logic [AW-1:0]   raddr,
  output mstt_pkg::slot_t rdata
);

  mstt_pkg::slot_t slot_mem [SLOTS];
  logic [SLOTS-1:0] vld_r;
  mstt_pkg::slot_t  rdata_r;
  logic             rvld_r;

  always_ff @(posedge clk) begin
    if (we) begin
      slot_mem[waddr] <= wdata;
    end
    rdata_r <= slot_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      rvld_r <= 1'b0;
    end else begin
      if (we) begin
        vld_r[waddr] <= 1'b1;
      end
      rvld_r <= vld_r[raddr];
    end
  end

  assign rdata = rvld_r ? rdata_r : '0;

endmodule

[src/multi_slot_timer_table.sv]
// multi-slot timer table: set, cancel and tick items over a slot memory
// uses mstt_pkg, mstt_slot_ram and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

//  channel  ports                        handshake
//  input    start, busy, in_item         taken when start && !busy
//  result   out_valid, out_item          one-cycle strobe, cannot be held off
//  config   cfg_valid, cfg_ready, cfg_data  written when cfg_valid && cfg_ready
//
// a set or cancel that goes ahead makes one pass over the slot memory to match,
// a write, a second pass to find the earliest due time, then the summary. a tick
// makes one pass that fires, reloads and finds the minimum together, then the
// summary; a rejected item goes straight to the summary. the slot memory has one
// read port and is read one entry per cycle.
// reset is synchronous, active low, and marks every slot free; results are never stalled.

module multi_slot_timer_table #(
  parameter int SLOTS  = 8,
  parameter int STATES = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  mstt_pkg::in_item_t in_item,
  output logic               out_valid,
  output mstt_pkg::out_item_t out_item,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam int FW = mstt_pkg::FIRE_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_MIN,
    ST_DONE
  } state_t;

  state_t                   state_r, state_nxt;
  mstt_pkg::in_item_t       item_r, item_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [AW-1:0]            tgt_r, tgt_nxt;
  logic                     tgt_ok_r, tgt_ok_nxt;
  logic                     dup_ok_r, dup_ok_nxt;
  logic                     dup_per_r, dup_per_nxt;
  logic [FW-1:0]            fired_r, fired_nxt;
  logic                     any_r, any_nxt;
  logic [31:0]              best_r, best_nxt;
  logic [31:0]              earliest_r, earliest_nxt;
  mstt_pkg::status_t        status_r, status_nxt;
  logic [31:0]              valid_states_r, valid_states_nxt;
  logic                     out_valid_r, out_valid_nxt;
  mstt_pkg::out_item_t      out_item_r, out_item_nxt;

  logic                     ram_we;
  logic [AW-1:0]            ram_waddr;
  mstt_pkg::slot_t          ram_wdata;
  logic [AW-1:0]            ram_raddr;
  mstt_pkg::slot_t          ent;

  logic [CW-1:0]            cnt_m1;
  logic [AW-1:0]            idx;
  logic                     end_pass;
  logic                     accept;
  logic                     reject;
  logic                     armed;
  logic                     due_hit;
  logic                     key_hit;
  mstt_pkg::slot_t          upd;
  logic                     cand_ok;
  logic [31:0]              cand_due;

  mstt_slot_ram #(
    .SLOTS (SLOTS),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ent)
  );

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  assign cnt_m1    = cnt_r - 1'b1;
  assign idx       = cnt_m1[AW-1:0];
  assign end_pass  = (cnt_r == CW'(SLOTS));
  assign ram_raddr = (cnt_r < CW'(SLOTS)) ? cnt_r[AW-1:0] : '0;

  // requests that are refused before touching the table
  always_comb begin
    reject = 1'b0;
    unique case (in_item.func)
      mstt_pkg::FUNC_SET: begin
        reject = (in_item.tmr_id == '0)
              || ({1'b0, in_item.owner_state} >= 6'(STATES))
              || !valid_states_r[in_item.owner_state]
              || ((in_item.delay == '0) && (in_item.reload_period == '0));
      end
      mstt_pkg::FUNC_CANCEL: reject = (in_item.tmr_id == '0);
      mstt_pkg::FUNC_TICK:   reject = 1'b0;
      default:               reject = 1'b1;
    endcase
  end

  // per-entry terms for the slot just read
  always_comb begin
    armed   = (ent.id != '0);
    key_hit = armed && (ent.id == item_r.tmr_id) && (ent.owner == item_r.owner_state);
    due_hit = armed && (ent.due <= item_r.now) && (fired_r < FW'(mstt_pkg::FIRE_CAP));
    upd     = ent;
    if (ent.period == '0) begin
      upd.id = '0;
    end else begin
      upd.due = mstt_pkg::sat_add(ent.due, ent.period);
    end
    if ((state_r == ST_SCAN) && due_hit) begin
      cand_ok  = (ent.period != '0);
      cand_due = upd.due;
    end else begin
      cand_ok  = armed;
      cand_due = ent.due;
    end
  end

  always_comb begin
    state_nxt        = state_r;
    item_nxt         = item_r;
    cnt_nxt          = cnt_r;
    tgt_nxt          = tgt_r;
    tgt_ok_nxt       = tgt_ok_r;
    dup_ok_nxt       = dup_ok_r;
    dup_per_nxt      = dup_per_r;
    fired_nxt        = fired_r;
    any_nxt          = any_r;
    best_nxt         = best_r;
    earliest_nxt     = earliest_r;
    status_nxt       = status_r;
    valid_states_nxt = valid_states_r;
    out_valid_nxt    = 1'b0;
    out_item_nxt     = out_item_r;
    ram_we           = 1'b0;
    ram_waddr        = idx;
    ram_wdata        = upd;

    if (cfg_valid && cfg_ready) begin
      valid_states_nxt = cfg_data;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          item_nxt    = in_item;
          cnt_nxt     = '0;
          tgt_ok_nxt  = 1'b0;
          dup_ok_nxt  = 1'b0;
          dup_per_nxt = 1'b0;
          fired_nxt   = '0;
          any_nxt     = 1'b0;
          best_nxt    = '0;
          if (reject) begin
            status_nxt = mstt_pkg::STAT_INVALID;
            state_nxt  = ST_DONE;
          end else begin
            status_nxt = mstt_pkg::STAT_OK;
            state_nxt  = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (cnt_r != '0) begin
          unique case (item_r.func)
            mstt_pkg::FUNC_SET: begin
              if (!dup_ok_r) begin
                if (!armed) begin
                  if (!tgt_ok_r) begin
                    tgt_nxt    = idx;
                    tgt_ok_nxt = 1'b1;
                  end
                end else if (key_hit) begin
                  tgt_nxt     = idx;
                  dup_ok_nxt  = 1'b1;
                  dup_per_nxt = (ent.period != '0);
                end
              end
            end
            mstt_pkg::FUNC_CANCEL: begin
              if (!dup_ok_r && key_hit) begin
                tgt_nxt    = idx;
                dup_ok_nxt = 1'b1;
              end
            end
            mstt_pkg::FUNC_TICK: begin
              if (due_hit) begin
                ram_we        = 1'b1;
                fired_nxt     = fired_r + 1'b1;
                out_valid_nxt = 1'b1;
                out_item_nxt  = '{kind: mstt_pkg::KIND_EXPIRY, status: mstt_pkg::STAT_OK,
                                  fired_tmr_id: ent.id, fired_state: ent.owner,
                                  next_due: '0, last: 1'b0};
              end
              if (cand_ok && (!any_r || (cand_due < best_r))) begin
                best_nxt = cand_due;
              end
              any_nxt = any_r || cand_ok;
            end
            default: begin
            end
          endcase

          if (end_pass) begin
            unique case (item_r.func)
              mstt_pkg::FUNC_SET: begin
                if (dup_ok_nxt && (dup_per_nxt || (item_r.reload_period != '0))) begin
                  status_nxt = mstt_pkg::STAT_EXISTS;
                  state_nxt  = ST_DONE;
                end else if (!dup_ok_nxt && !tgt_ok_nxt) begin
                  status_nxt = mstt_pkg::STAT_FULL;
                  state_nxt  = ST_DONE;
                end else begin
                  state_nxt = ST_WRITE;
                end
              end
              mstt_pkg::FUNC_CANCEL: begin
                if (dup_ok_nxt) begin
                  state_nxt = ST_WRITE;
                end else begin
                  status_nxt = mstt_pkg::STAT_NOT_FOUND;
                  state_nxt  = ST_DONE;
                end
              end
              default: begin
                earliest_nxt = any_nxt ? best_nxt : '0;
                state_nxt    = ST_DONE;
              end
            endcase
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_WRITE: begin
        ram_we    = 1'b1;
        ram_waddr = tgt_r;
        if (item_r.func == mstt_pkg::FUNC_SET) begin
          ram_wdata.id     = item_r.tmr_id;
          ram_wdata.owner  = item_r.owner_state;
          ram_wdata.due    = mstt_pkg::sat_add(item_r.now,
                               (item_r.delay == '0) ? item_r.reload_period : item_r.delay);
          ram_wdata.period = item_r.reload_period;
        end else begin
          ram_wdata = '0;
        end
        cnt_nxt   = '0;
        any_nxt   = 1'b0;
        best_nxt  = '0;
        state_nxt = ST_MIN;
      end

      ST_MIN: begin
        if (cnt_r != '0) begin
          if (cand_ok && (!any_r || (cand_due < best_r))) begin
            best_nxt = cand_due;
          end
          any_nxt = any_r || cand_ok;
          if (end_pass) begin
            earliest_nxt = any_nxt ? best_nxt : '0;
            state_nxt    = ST_DONE;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      ST_DONE: begin
        out_valid_nxt = 1'b1;
        out_item_nxt  = '{kind: mstt_pkg::KIND_STATUS, status: status_r,
                          fired_tmr_id: '0, fired_state: '0,
                          next_due: earliest_r, last: 1'b1};
        state_nxt     = ST_IDLE;
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    tgt_r      <= tgt_nxt;
    best_r     <= best_nxt;
    status_r   <= status_nxt;
    out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cnt_r          <= '0;
      tgt_ok_r       <= 1'b0;
      dup_ok_r       <= 1'b0;
      dup_per_r      <= 1'b0;
      fired_r        <= '0;
      any_r          <= 1'b0;
      earliest_r     <= '0;
      valid_states_r <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cnt_r          <= cnt_nxt;
      tgt_ok_r       <= tgt_ok_nxt;
      dup_ok_r       <= dup_ok_nxt;
      dup_per_r      <= dup_per_nxt;
      fired_r        <= fired_nxt;
      any_r          <= any_nxt;
      earliest_r     <= earliest_nxt;
      valid_states_r <= valid_states_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  `ASSERT_CLK(a_exp_busy, (out_valid_r && !out_item_r.last) |-> busy, "expiry outside a tick")
  `ASSERT_CLK(a_sum_due, (out_valid_r && out_item_r.last) |-> (out_item_r.next_due == earliest_r), "stale next_due")
  `ASSERT_CLK(a_wr_busy, ram_we |-> ((state_r == ST_SCAN) || (state_r == ST_WRITE)), "stray slot write")
  `ASSERT_NEXT(a_accept_quiet, start && !busy, !out_valid_r, "result item right after accept")

endmodule
